@@ rtl/core/ecsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared types, constants and the microcode table for the scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;

   localparam int COORD_BITS  = 16;
   localparam int SCALAR_BITS = 32;
   localparam int CNT_BITS    = $clog2(COORD_BITS);
   localparam int PC_BITS     = 6;

   localparam logic [COORD_BITS-1:0] MODULUS_RESET = COORD_BITS'(65521);

   // register indexes on the configuration port
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_COEFF_A = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOINV = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;

   // microcode entry points
   localparam logic [PC_BITS-1:0] DBL_ENTRY   = PC_BITS'(0);
   localparam logic [PC_BITS-1:0] ADD_ENTRY   = PC_BITS'(16);
   localparam logic [PC_BITS-1:0] INV_ENTRY   = PC_BITS'(29);
   localparam logic [PC_BITS-1:0] INV_LOOP    = PC_BITS'(30);
   localparam logic [PC_BITS-1:0] INV_CHECK   = PC_BITS'(36);
   localparam logic [PC_BITS-1:0] SETUP_ENTRY = PC_BITS'(37);

   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_MOV, OP_MUL, OP_MODR,
      OP_INVI, OP_DIV, OP_ROT, OP_TAKE, OP_SHK, OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      R_ZERO, R_BX, R_BY, R_AX, R_AY, R_U, R_V, R_W, R_T0, R_T1, R_Q, R_AC
   } reg_sel_type;

   typedef enum logic [2:0] {
      K_DP, K_CALL, K_BRZ, K_JMP, K_CHK, K_END
   } uop_kind_type;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_EXEC, S_WAIT, S_SCAN, S_SCAN2, S_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_SETUP, PH_ADD, PH_DBL
   } phase_type;

   typedef struct packed {
      logic        go;
      dp_op_type   op;
      reg_sel_type dst;
      reg_sel_type sa;
      reg_sel_type sb;
      logic [1:0]  est;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic out_full;
      logic m_small;
      logic k_zero;
      logic k_bit0;
      logic k_rest_zero;
      logic r1_zero;
      logic r0_one;
   } stat_type;

   typedef struct packed {
      uop_kind_type       kind;
      dp_op_type          op;
      reg_sel_type        dst;
      reg_sel_type        sa;
      reg_sel_type        sb;
      logic [PC_BITS-1:0] tgt;
   } uword_type;

   function automatic uword_type uw(uop_kind_type k, dp_op_type op, reg_sel_type d,
                                    reg_sel_type a, reg_sel_type b,
                                    logic [PC_BITS-1:0] t);
      uword_type w;
      w.kind = k;
      w.op   = op;
      w.dst  = d;
      w.sa   = a;
      w.sb   = b;
      w.tgt  = t;
      return w;
   endfunction

   function automatic uword_type dp(dp_op_type op, reg_sel_type d, reg_sel_type a,
                                    reg_sel_type b);
      return uw(K_DP, op, d, a, b, '0);
   endfunction

   function automatic uword_type fl(uop_kind_type k, logic [PC_BITS-1:0] t);
      return uw(k, OP_NOP, R_ZERO, R_ZERO, R_ZERO, t);
   endfunction

   // microcode: doubling, addition, inversion, input setup
   function automatic uword_type rom_word(logic [PC_BITS-1:0] pc);
      uword_type w;
      unique case (pc)
         // point doubling of (bx, by)
         6'd0:  w = dp(OP_MUL, R_U, R_BX, R_BX);
         6'd1:  w = dp(OP_ADD, R_V, R_U, R_U);
         6'd2:  w = dp(OP_ADD, R_V, R_V, R_U);
         6'd3:  w = dp(OP_ADD, R_V, R_V, R_AC);
         6'd4:  w = dp(OP_ADD, R_W, R_BY, R_BY);
         6'd5:  w = fl(K_CALL, INV_ENTRY);
         6'd6:  w = dp(OP_MUL, R_W, R_V, R_T0);
         6'd7:  w = dp(OP_MUL, R_U, R_W, R_W);
         6'd8:  w = dp(OP_SUB, R_U, R_U, R_BX);
         6'd9:  w = dp(OP_SUB, R_U, R_U, R_BX);
         6'd10: w = dp(OP_SUB, R_V, R_BX, R_U);
         6'd11: w = dp(OP_MUL, R_V, R_W, R_V);
         6'd12: w = dp(OP_SUB, R_V, R_V, R_BY);
         6'd13: w = dp(OP_MOV, R_BX, R_U, R_ZERO);
         6'd14: w = dp(OP_MOV, R_BY, R_V, R_ZERO);
         6'd15: w = fl(K_END, '0);
         // point addition (ax, ay) += (bx, by)
         6'd16: w = dp(OP_SUB, R_V, R_BY, R_AY);
         6'd17: w = dp(OP_SUB, R_W, R_BX, R_AX);
         6'd18: w = fl(K_CALL, INV_ENTRY);
         6'd19: w = dp(OP_MUL, R_W, R_V, R_T0);
         6'd20: w = dp(OP_MUL, R_U, R_W, R_W);
         6'd21: w = dp(OP_SUB, R_U, R_U, R_AX);
         6'd22: w = dp(OP_SUB, R_U, R_U, R_BX);
         6'd23: w = dp(OP_SUB, R_V, R_AX, R_U);
         6'd24: w = dp(OP_MUL, R_V, R_W, R_V);
         6'd25: w = dp(OP_SUB, R_V, R_V, R_AY);
         6'd26: w = dp(OP_MOV, R_AX, R_U, R_ZERO);
         6'd27: w = dp(OP_MOV, R_AY, R_V, R_ZERO);
         6'd28: w = fl(K_END, '0);
         // extended Euclid inverse of w, result in t0
         6'd29: w = dp(OP_INVI, R_ZERO, R_W, R_ZERO);
         6'd30: w = fl(K_BRZ, INV_CHECK);
         6'd31: w = dp(OP_DIV, R_ZERO, R_ZERO, R_ZERO);
         6'd32: w = dp(OP_MUL, R_Q, R_Q, R_T1);
         6'd33: w = dp(OP_SUB, R_Q, R_T0, R_Q);
         6'd34: w = dp(OP_ROT, R_ZERO, R_ZERO, R_ZERO);
         6'd35: w = fl(K_JMP, INV_LOOP);
         6'd36: w = fl(K_CHK, '0);
         // reduce inputs and coefficient
         6'd37: w = dp(OP_MODR, R_BX, R_BX, R_ZERO);
         6'd38: w = dp(OP_MODR, R_BY, R_BY, R_ZERO);
         6'd39: w = dp(OP_MODR, R_AC, R_AC, R_ZERO);
         6'd40: w = fl(K_END, '0);
         default: w = fl(K_END, '0);
      endcase
      return w;
   endfunction

   // a + b mod m for a, b < m
   function automatic logic [COORD_BITS-1:0] madd(logic [COORD_BITS-1:0] a,
                                                  logic [COORD_BITS-1:0] b,
                                                  logic [COORD_BITS-1:0] m);
      logic [COORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[COORD_BITS-1:0];
   endfunction

   // a - b mod m for a, b < m
   function automatic logic [COORD_BITS-1:0] msub(logic [COORD_BITS-1:0] a,
                                                  logic [COORD_BITS-1:0] b,
                                                  logic [COORD_BITS-1:0] m);
      logic [COORD_BITS-1:0] d;
      d = a - b;
      if (a < b) d = d + m;
      return d;
   endfunction

endpackage

@@ rtl/core/ecsm_dp.sv @@
// ----------------------------------------------------------------------------
// ecsm_dp
// Datapath: working registers, modular add/sub, a bit-serial unit
// for modular multiply and remainder/division, scalar shifter, result register.
// ----------------------------------------------------------------------------
module ecsm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  ecsm_pkg::cmd_type                 cmd,
   output ecsm_pkg::stat_type                stat,
   input  logic [2*ecsm_pkg::COORD_BITS+ecsm_pkg::SCALAR_BITS-1:0] req_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_index,
   input  logic [ecsm_pkg::COORD_BITS-1:0]   csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*ecsm_pkg::COORD_BITS-1:0] rsp_tdata,
   output logic [1:0]                        rsp_tuser
);
   import ecsm_pkg::*;

   localparam int W = COORD_BITS;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(COORD_BITS - 1);

   // configuration
   logic [W-1:0] modulus_ff, coeff_a_ff;

   // working registers
   logic [W-1:0] bx_ff, by_ff, ax_ff, ay_ff, u_ff, v_ff, w_ff, ac_ff;
   logic [W-1:0] t0_ff, t1_ff, r0_ff, r1_ff, q_ff, rem_ff;
   logic [SCALAR_BITS-1:0] k_ff;

   // serial unit
   logic              busy_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   dp_op_type         mode_ff;
   reg_sel_type       dst_ff;
   logic [W-1:0]      acc_ff, sh_ff, dv_ff, ma_ff;
   logic [W-1:0]      acc_in, sh_in;

   // result register
   logic              rsp_valid_ff;
   logic [W-1:0]      rsp_x_ff, rsp_y_ff;
   logic [1:0]        rsp_st_ff;

   logic [W-1:0] m, q_red, opa, opb;
   logic         wr_en;
   reg_sel_type  wr_sel;
   logic [W-1:0] wr_data;
   logic         ser_last;
   logic [W:0]   r_ext;
   logic         ge;
   logic [W-1:0] d1, d2;

   function automatic logic [W-1:0] rd(reg_sel_type s, logic [W-1:0] qr);
      logic [W-1:0] r;
      unique case (s)
         R_BX:    r = bx_ff;
         R_BY:    r = by_ff;
         R_AX:    r = ax_ff;
         R_AY:    r = ay_ff;
         R_U:     r = u_ff;
         R_V:     r = v_ff;
         R_W:     r = w_ff;
         R_T0:    r = t0_ff;
         R_T1:    r = t1_ff;
         R_Q:     r = qr;
         R_AC:    r = ac_ff;
         default: r = '0;
      endcase
      return r;
   endfunction

   assign m     = modulus_ff;
   // q can reach m only when r1 is one; fold it back below m
   assign q_red = (q_ff >= m) ? q_ff - m : q_ff;
   assign opa   = rd(cmd.sa, q_red);
   assign opb   = rd(cmd.sb, q_red);

   // one serial step: remainder shift-subtract and double-and-add multiply
   always_comb begin
      r_ext = {acc_ff, sh_ff[W-1]};
      ge    = r_ext >= {1'b0, dv_ff};
      d1    = madd(acc_ff, acc_ff, m);
      d2    = sh_ff[W-1] ? madd(d1, ma_ff, m) : d1;
      if (mode_ff == OP_MUL) begin
         acc_in = d2;
         sh_in  = {sh_ff[W-2:0], 1'b0};
      end else begin
         acc_in = ge ? W'(r_ext - {1'b0, dv_ff}) : r_ext[W-1:0];
         sh_in  = {sh_ff[W-2:0], ge};
      end
   end

   assign ser_last = busy_ff && (cnt_ff == CNT_LAST);

   // write port of the general registers
   always_comb begin
      wr_en   = 1'b0;
      wr_sel  = cmd.dst;
      wr_data = '0;
      if (ser_last && (mode_ff == OP_MUL || mode_ff == OP_MODR)) begin
         wr_en   = 1'b1;
         wr_sel  = dst_ff;
         wr_data = acc_in;
      end else if (cmd.go) begin
         priority case (cmd.op)
            OP_ADD: begin wr_en = 1'b1; wr_data = madd(opa, opb, m); end
            OP_SUB: begin wr_en = 1'b1; wr_data = msub(opa, opb, m); end
            OP_MOV: begin wr_en = 1'b1; wr_data = opa; end
            default: wr_en = 1'b0;
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         coeff_a_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_MODULUS) modulus_ff <= csr_data;
         else                          coeff_a_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.go && cmd.op == OP_LOAD) begin
         bx_ff <= req_tdata[W-1:0];
         by_ff <= req_tdata[2*W-1:W];
         k_ff  <= req_tdata[2*W+SCALAR_BITS-1:2*W];
         ac_ff <= coeff_a_ff;
      end
      if (cmd.go && cmd.op == OP_SHK) k_ff <= k_ff >> 1;
      if (cmd.go && cmd.op == OP_TAKE) begin
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
      end
      if (cmd.go && cmd.op == OP_INVI) begin
         r0_ff <= m;
         r1_ff <= opa;
         t0_ff <= '0;
         t1_ff <= W'(1);
      end
      if (cmd.go && cmd.op == OP_ROT) begin
         r0_ff <= r1_ff;
         r1_ff <= rem_ff;
         t0_ff <= t1_ff;
         t1_ff <= q_ff;
      end
      if (ser_last && mode_ff == OP_DIV) begin
         q_ff   <= sh_in;
         rem_ff <= acc_in;
      end
      if (wr_en) begin
         unique case (wr_sel)
            R_BX:    bx_ff <= wr_data;
            R_BY:    by_ff <= wr_data;
            R_AX:    ax_ff <= wr_data;
            R_AY:    ay_ff <= wr_data;
            R_U:     u_ff  <= wr_data;
            R_V:     v_ff  <= wr_data;
            R_W:     w_ff  <= wr_data;
            R_T0:    t0_ff <= wr_data;
            R_T1:    t1_ff <= wr_data;
            R_Q:     q_ff  <= wr_data;
            R_AC:    ac_ff <= wr_data;
            default: ;
         endcase
      end
   end

   // serial unit control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.go && (cmd.op == OP_MUL || cmd.op == OP_MODR
                              || cmd.op == OP_DIV)) begin
         busy_ff <= 1'b1;
      end else if (ser_last) begin
         busy_ff <= 1'b0;
      end
   end

   // serial unit operands and step
   always_ff @(posedge clock) begin
      if (cmd.go && (cmd.op == OP_MUL || cmd.op == OP_MODR || cmd.op == OP_DIV)) begin
         cnt_ff  <= '0;
         acc_ff  <= '0;
         mode_ff <= cmd.op;
         dst_ff  <= cmd.dst;
         ma_ff   <= opa;
         unique case (cmd.op)
            OP_MUL:  begin sh_ff <= opb;   dv_ff <= m;     end
            OP_DIV:  begin sh_ff <= r0_ff; dv_ff <= r1_ff; end
            default: begin sh_ff <= opa;   dv_ff <= m;     end
         endcase
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_BITS'(1);
         acc_ff <= acc_in;
         sh_ff  <= sh_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.go && cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go && cmd.op == OP_EMIT) begin
         rsp_st_ff <= cmd.est;
         unique case (cmd.sa)
            R_AX:    begin rsp_x_ff <= ax_ff; rsp_y_ff <= ay_ff; end
            R_BX:    begin rsp_x_ff <= bx_ff; rsp_y_ff <= by_ff; end
            default: begin rsp_x_ff <= '0;    rsp_y_ff <= '0;    end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_st_ff;

   // status toward the controller
   always_comb begin
      stat.busy        = busy_ff;
      stat.out_full    = rsp_valid_ff;
      stat.m_small     = m < W'(2);
      stat.k_zero      = k_ff == '0;
      stat.k_bit0      = k_ff[0];
      stat.k_rest_zero = (k_ff >> 1) == '0;
      stat.r1_zero     = r1_ff == '0;
      stat.r0_one      = r0_ff == W'(1);
   end

   // no result is written over one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.go && cmd.op == OP_EMIT |-> !rsp_valid_ff)
      else $error("result emitted over pending result");

   // no new command while the serial unit runs
   a_no_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.go)
      else $error("command issued while serial unit busy");

   // the serial unit starts each operation from a zero count
   a_ser_len: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == '0)
      else $error("serial unit started with stale count");

endmodule

@@ rtl/core/ecsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ecsm_ctrl
// Controller: scans the scalar, sequences the microcode for setup, doubling,
// addition and inversion, and issues datapath commands.
// ----------------------------------------------------------------------------
module ecsm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output ecsm_pkg::cmd_type  cmd,
   input  ecsm_pkg::stat_type stat
);
   import ecsm_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in, ret_ff, ret_in;
   phase_type          phase_ff, phase_in;
   logic               have_ff, have_in;
   reg_sel_type        esel_ff, esel_in;
   logic [1:0]         est_ff, est_in;
   uword_type          uw;

   assign uw = rom_word(pc_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         ret_ff   <= '0;
         phase_ff <= PH_SETUP;
         have_ff  <= 1'b0;
         esel_ff  <= R_ZERO;
         est_ff   <= ST_OK;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         ret_ff   <= ret_in;
         phase_ff <= phase_in;
         have_ff  <= have_in;
         esel_ff  <= esel_in;
         est_ff   <= est_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      ret_in     = ret_ff;
      phase_in   = phase_ff;
      have_in    = have_ff;
      esel_in    = esel_ff;
      est_in     = est_ff;
      req_tready = 1'b0;
      cmd.go     = 1'b0;
      cmd.op     = OP_NOP;
      cmd.dst    = R_ZERO;
      cmd.sa     = R_ZERO;
      cmd.sb     = R_ZERO;
      cmd.est    = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.go   = 1'b1;
               cmd.op   = OP_LOAD;
               have_in  = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (stat.m_small) begin
               esel_in  = R_ZERO;
               est_in   = stat.k_zero ? ST_ZERO : ST_NOINV;
               state_in = S_EMIT;
            end else begin
               pc_in    = SETUP_ENTRY;
               phase_in = PH_SETUP;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (uw.kind)
               K_DP: begin
                  cmd.go   = 1'b1;
                  cmd.op   = uw.op;
                  cmd.dst  = uw.dst;
                  cmd.sa   = uw.sa;
                  cmd.sb   = uw.sb;
                  state_in = S_WAIT;
               end
               K_CALL: begin
                  ret_in = pc_ff + PC_BITS'(1);
                  pc_in  = uw.tgt;
               end
               K_BRZ: pc_in = stat.r1_zero ? uw.tgt : pc_ff + PC_BITS'(1);
               K_JMP: pc_in = uw.tgt;
               K_CHK: begin
                  // gcd must be one, else the slope does not exist
                  if (stat.r0_one) begin
                     pc_in = ret_ff;
                  end else begin
                     esel_in  = R_ZERO;
                     est_in   = ST_NOINV;
                     state_in = S_EMIT;
                  end
               end
               default: begin
                  unique case (phase_ff)
                     PH_SETUP: begin
                        if (stat.k_zero) begin
                           esel_in  = R_BX;
                           est_in   = ST_ZERO;
                           state_in = S_EMIT;
                        end else begin
                           state_in = S_SCAN;
                        end
                     end
                     PH_ADD: state_in = S_SCAN2;
                     default: begin
                        cmd.go   = 1'b1;
                        cmd.op   = OP_SHK;
                        state_in = S_SCAN;
                     end
                  endcase
               end
            endcase
         end
         S_WAIT: begin
            if (!stat.busy) begin
               pc_in    = pc_ff + PC_BITS'(1);
               state_in = S_EXEC;
            end
         end
         S_SCAN: begin
            // current scalar bit: take or add the running base point
            if (stat.k_bit0 && have_ff) begin
               pc_in    = ADD_ENTRY;
               phase_in = PH_ADD;
               state_in = S_EXEC;
            end else if (stat.k_bit0) begin
               cmd.go   = 1'b1;
               cmd.op   = OP_TAKE;
               have_in  = 1'b1;
               state_in = S_SCAN2;
            end else begin
               state_in = S_SCAN2;
            end
         end
         S_SCAN2: begin
            // stop once no higher bit is set, else double
            if (stat.k_rest_zero) begin
               esel_in  = R_AX;
               est_in   = ST_OK;
               state_in = S_EMIT;
            end else begin
               pc_in    = DBL_ENTRY;
               phase_in = PH_DBL;
               state_in = S_EXEC;
            end
         end
         default: begin
            if (!stat.out_full) begin
               cmd.go   = 1'b1;
               cmd.op   = OP_EMIT;
               cmd.sa   = esel_ff;
               cmd.est  = est_ff;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // the serial unit only starts from a microcode step
   a_busy_src: assert property (@(posedge clock) disable iff (reset)
      $rose(stat.busy) |-> $past(state_ff) == S_EXEC)
      else $error("serial unit started outside microcode");

   // idle means no datapath work in flight
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !stat.busy)
      else $error("idle with serial unit busy");

   // a finished wait always moves on to the next step
   a_wait_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT && !stat.busy |=> state_ff == S_EXEC)
      else $error("wait did not advance");

endmodule

@@ rtl/core/ecc_scalar_multiply_modp.sv @@
// ----------------------------------------------------------------------------
// ecc_scalar_multiply_modp
// Affine double-and-add scalar multiplication on y^2 = x^3 + a*x + b mod p.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request = base point and scalar. Accepted when the block is
//            idle (req_tready high), one request at a time.
//   rsp_*  : one result per request, held in an output register until taken.
//            The next request is accepted while a result still waits; the
//            block only stalls at the very end if the previous result is
//            still pending.
//   csr_*  : register writes (0 modulus, 1 coefficient a), always ready;
//            write only while no request is in flight.
// Timing: steps run one after another on one shared datapath. Each modular
//   multiply or reduction occupies the bit-serial unit until it is done, and
//   the next step waits for it; each inversion runs one Euclid iteration after
//   another, so the work per request grows with the set and examined scalar
//   bits, less for small k.
//   Zero scalar or a modulus below two ends without any point arithmetic.
// Reset: synchronous; modulus returns to 65521, a to 0, no result pending.
// ----------------------------------------------------------------------------
module ecc_scalar_multiply_modp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // base_x[15:0], base_y[31:16], scalar[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_x[15:0], result_y[31:16]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   import ecsm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   ecsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // arithmetic and storage
   ecsm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
